// ===== rtl/core/i2cm_pkg.sv =====
// Shared types and codes for the I2C master transaction engine.
`default_nettype none

package i2cm_pkg;

    localparam int unsigned ACK_TIMEOUT_RESET = 250;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_READ  = 2'd2,
        KIND_DATA  = 2'd3
    } t_kind;

    // Register index as decoded from paddr[2]
    typedef enum logic {
        REG_ACK_TIMEOUT = 1'b0,
        REG_NONE        = 1'b1
    } t_reg;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic [7:0] third_byte;
        logic [7:0] byte_count;
        logic [7:0] data_byte;
        logic       sda_in;
    } t_item;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       need_data;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       last_read;
        logic       done_res;
        logic       status;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/i2c_master_transaction_engine.sv =====
// Top level of the I2C master transaction engine: stream ports, pipeline registers, APB.
// The engine takes one transaction per clock while the result stream does not stall: each
// is captured in the input register, then stepped through the bus phase sequencer into
// the result register. s_axis_tready falls only while the result register is full and
// m_axis_tready is low. A tick advances the bus one quarter bit, four ticks making one bit,
// except while idle or waiting for data or an ack. ack_timeout is written over APB at byte
// addresses 0 to 3 by the user only while the engine is idle, not enforced by the block.
`default_nettype none

module i2c_master_transaction_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // first_byte[7:0], second_byte[15:8], third_byte[23:16], byte_count[31:24],
    // data_byte[39:32], sda_in[40], zero[47:41]
    input  wire logic [47:0] s_axis_tdata,
    // kind[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // scl_out[0], sda_out[1], busy_res[2], need_data[3], read_byte[11:4],
    // done_res[12], status[13], zero[15:14]
    output logic [15:0]      m_axis_tdata,
    // read_valid[0]
    output logic             m_axis_tuser,
    // last_read
    output logic             m_axis_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import i2cm_pkg::*;

    logic        r_in_valid;
    t_item       r_in;
    logic        r_out_valid;
    t_result     r_out;
    logic        w_advance;
    logic        w_step;
    logic [15:0] w_ack_timeout;
    t_result     w_result;

    assign w_advance     = !r_out_valid || m_axis_tready;
    assign w_step        = r_in_valid && w_advance;
    assign s_axis_tready = !r_in_valid || w_advance;

    i2cm_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_ack_timeout (w_ack_timeout)
    );

    i2cm_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_step),
        .i_item        (r_in),
        .i_ack_timeout (w_ack_timeout),
        .o_result      (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.kind        <= t_kind'(s_axis_tuser);
            r_in.first_byte  <= s_axis_tdata[7:0];
            r_in.second_byte <= s_axis_tdata[15:8];
            r_in.third_byte  <= s_axis_tdata[23:16];
            r_in.byte_count  <= s_axis_tdata[31:24];
            r_in.data_byte   <= s_axis_tdata[39:32];
            r_in.sda_in      <= s_axis_tdata[40];
        end
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.status, r_out.done_res, r_out.read_byte,
                            r_out.need_data, r_out.busy_res, r_out.sda_out, r_out.scl_out};
    assign m_axis_tuser  = r_out.read_valid;
    assign m_axis_tlast  = r_out.last_read;

endmodule

`default_nettype wire

// ===== rtl/core/i2cm_regs.sv =====
// APB configuration register block for the I2C master.
`default_nettype none

module i2cm_regs (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic [15:0]      o_ack_timeout
);
    import i2cm_pkg::*;

    logic [15:0] r_ack_timeout;
    logic        w_write;

    assign pready  = 1'b1;
    assign w_write = psel && penable && pwrite && (paddr[2] == REG_ACK_TIMEOUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_timeout <= 16'(ACK_TIMEOUT_RESET);
        end else if (w_write) begin
            r_ack_timeout <= pwdata[15:0];
        end
    end

    always_comb begin
        if (paddr[2] == REG_ACK_TIMEOUT) begin
            prdata = {16'd0, r_ack_timeout};
        end else begin
            prdata = 32'd0;
        end
    end

    assign o_ack_timeout = r_ack_timeout;

endmodule

`default_nettype wire

// ===== rtl/core/i2cm_core.sv =====
// Bus phase sequencer: state registers and the next-state and drive logic of one step.
`default_nettype none

module i2cm_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  i2cm_pkg::t_item       i_item,
    input  wire logic [15:0]      i_ack_timeout,
    output i2cm_pkg::t_result     o_result
);
    import i2cm_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_START      = 4'd1,
        PH_SEND_H0    = 4'd2,
        PH_ACK_H0     = 4'd3,
        PH_SEND_H1    = 4'd4,
        PH_ACK_H1     = 4'd5,
        PH_SEND_DATA  = 4'd6,
        PH_ACK_DATA   = 4'd7,
        PH_RESTART    = 4'd8,
        PH_SEND_H2    = 4'd9,
        PH_ACK_H2     = 4'd10,
        PH_READ       = 4'd11,
        PH_ACK_OUT    = 4'd12,
        PH_STOP_OK    = 4'd13,
        PH_STOP_ABORT = 4'd14,
        PH_WAIT_DATA  = 4'd15
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_qtr, n_qtr;
    logic [2:0]  r_bit, n_bit;
    logic [7:0]  r_shift, n_shift;
    logic [7:0]  r_hdr0, n_hdr0;
    logic [7:0]  r_hdr1, n_hdr1;
    logic [7:0]  r_hdr2, n_hdr2;
    logic [7:0]  r_left, n_left;
    logic [7:0]  r_hold, n_hold;
    logic        r_hold_full, n_hold_full;
    logic [15:0] r_ack_cnt, n_ack_cnt;
    logic        r_is_read, n_is_read;

    logic        w_last_q;
    logic        w_try;
    logic [7:0]  w_rd_shift;
    logic [7:0]  w_rbyte;
    logic        w_rvalid;
    logic        w_rlast;
    logic        w_done;
    logic        w_stat;
    logic        w_scl;
    logic        w_sda;

    assign w_last_q   = (r_qtr == 2'd3);
    assign w_rd_shift = {r_shift[6:0], i_item.sda_in};

    always_comb begin
        n_phase     = r_phase;
        n_qtr       = r_qtr;
        n_bit       = r_bit;
        n_shift     = r_shift;
        n_hdr0      = r_hdr0;
        n_hdr1      = r_hdr1;
        n_hdr2      = r_hdr2;
        n_left      = r_left;
        n_hold      = r_hold;
        n_hold_full = r_hold_full;
        n_ack_cnt   = r_ack_cnt;
        n_is_read   = r_is_read;
        w_try       = 1'b0;
        w_rbyte     = 8'd0;
        w_rvalid    = 1'b0;
        w_rlast     = 1'b0;
        w_done      = 1'b0;
        w_stat      = 1'b0;
        if (i_step) begin
            unique case (i_item.kind)
                KIND_WRITE, KIND_READ: begin
                    if (r_phase == PH_IDLE) begin
                        n_hdr0      = i_item.first_byte;
                        n_hdr1      = i_item.second_byte;
                        n_hdr2      = i_item.third_byte;
                        n_left      = i_item.byte_count;
                        n_is_read   = (i_item.kind == KIND_READ);
                        n_hold_full = 1'b0;
                        n_ack_cnt   = 16'd0;
                        n_phase     = PH_START;
                        n_qtr       = 2'd0;
                        n_bit       = 3'd0;
                    end
                end
                KIND_DATA: begin
                    if (r_phase != PH_IDLE && !r_is_read && !r_hold_full) begin
                        n_hold      = i_item.data_byte;
                        n_hold_full = 1'b1;
                    end
                end
                KIND_TICK: begin
                    if (r_phase != PH_IDLE) begin
                        if (!w_last_q && r_phase != PH_WAIT_DATA) begin
                            n_qtr = r_qtr + 2'd1;
                        end else begin
                            n_qtr = 2'd0;
                            n_bit = 3'd0;
                            unique case (r_phase)
                                PH_START: begin
                                    n_phase = PH_SEND_H0;
                                    n_shift = r_hdr0;
                                end
                                PH_RESTART: begin
                                    n_phase = PH_SEND_H2;
                                    n_shift = r_hdr2;
                                end
                                PH_SEND_H0, PH_SEND_H1, PH_SEND_H2, PH_SEND_DATA: begin
                                    if (r_bit != 3'd7) begin
                                        n_bit   = r_bit + 3'd1;
                                        n_shift = {r_shift[6:0], 1'b0};
                                    end else begin
                                        n_ack_cnt = 16'd0;
                                        priority case (r_phase)
                                            PH_SEND_H0: n_phase = PH_ACK_H0;
                                            PH_SEND_H1: n_phase = PH_ACK_H1;
                                            PH_SEND_H2: n_phase = PH_ACK_H2;
                                            default:    n_phase = PH_ACK_DATA;
                                        endcase
                                    end
                                end
                                PH_ACK_H0, PH_ACK_H1, PH_ACK_H2, PH_ACK_DATA: begin
                                    if (!i_item.sda_in) begin
                                        priority if (r_phase == PH_ACK_H0) begin
                                            n_phase = PH_SEND_H1;
                                            n_shift = r_hdr1;
                                        end else if (r_phase == PH_ACK_H1 && r_is_read) begin
                                            n_phase = PH_RESTART;
                                        end else if (r_left == 8'd0) begin
                                            n_phase = PH_STOP_OK;
                                        end else if (r_phase == PH_ACK_H2) begin
                                            n_phase = PH_READ;
                                            n_shift = 8'd0;
                                        end else begin
                                            w_try = 1'b1;
                                        end
                                    end else if (r_ack_cnt >= i_ack_timeout) begin
                                        n_phase = PH_STOP_ABORT;
                                    end else begin
                                        n_ack_cnt = r_ack_cnt + 16'd1;
                                        n_qtr     = r_qtr;
                                        n_bit     = r_bit;
                                    end
                                end
                                PH_WAIT_DATA: begin
                                    w_try = 1'b1;
                                end
                                PH_READ: begin
                                    n_shift = w_rd_shift;
                                    if (r_bit != 3'd7) begin
                                        n_bit = r_bit + 3'd1;
                                    end else begin
                                        if (r_left != 8'd0) begin
                                            n_left = r_left - 8'd1;
                                        end
                                        w_rbyte  = w_rd_shift;
                                        w_rvalid = 1'b1;
                                        w_rlast  = (n_left == 8'd0);
                                        n_phase  = PH_ACK_OUT;
                                    end
                                end
                                PH_ACK_OUT: begin
                                    if (r_left == 8'd0) begin
                                        n_phase = PH_STOP_OK;
                                    end else begin
                                        n_phase = PH_READ;
                                        n_shift = 8'd0;
                                    end
                                end
                                PH_STOP_OK, PH_STOP_ABORT: begin
                                    w_done      = 1'b1;
                                    w_stat      = (r_phase == PH_STOP_ABORT);
                                    n_hold_full = 1'b0;
                                    n_phase     = PH_IDLE;
                                end
                                PH_IDLE: begin
                                    n_phase = PH_IDLE;
                                end
                            endcase
                        end
                        if (w_try) begin
                            if (r_hold_full) begin
                                n_phase     = PH_SEND_DATA;
                                n_shift     = r_hold;
                                n_hold_full = 1'b0;
                                n_left      = r_left - 8'd1;
                            end else begin
                                n_phase = PH_WAIT_DATA;
                            end
                        end
                    end
                end
            endcase
        end
    end

    // Line drive follows the state after the step
    always_comb begin
        unique case (n_phase)
            PH_START: begin
                w_scl = !n_qtr[1];
                w_sda = (n_qtr == 2'd0);
            end
            PH_SEND_H0, PH_SEND_H1, PH_SEND_H2, PH_SEND_DATA: begin
                w_scl = n_qtr[1];
                w_sda = n_shift[7];
            end
            PH_ACK_H0, PH_ACK_H1, PH_ACK_H2, PH_ACK_DATA, PH_READ: begin
                w_scl = n_qtr[1];
                w_sda = 1'b1;
            end
            PH_RESTART: begin
                w_scl = (n_qtr == 2'd1) || (n_qtr == 2'd2);
                w_sda = !n_qtr[1];
            end
            PH_ACK_OUT: begin
                w_scl = n_qtr[1];
                w_sda = (n_left == 8'd0);
            end
            PH_STOP_OK, PH_STOP_ABORT: begin
                w_scl = (n_qtr != 2'd0);
                w_sda = n_qtr[1];
            end
            PH_WAIT_DATA: begin
                w_scl = 1'b0;
                w_sda = 1'b1;
            end
            PH_IDLE: begin
                w_scl = 1'b1;
                w_sda = 1'b1;
            end
        endcase
    end

    always_comb begin
        o_result.scl_out    = w_scl;
        o_result.sda_out    = w_sda;
        o_result.busy_res   = (n_phase != PH_IDLE);
        o_result.need_data  = (n_phase != PH_IDLE) && !n_is_read && (n_left != 8'd0)
                              && !n_hold_full;
        o_result.read_byte  = w_rbyte;
        o_result.read_valid = w_rvalid;
        o_result.last_read  = w_rlast;
        o_result.done_res   = w_done;
        o_result.status     = w_stat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_qtr       <= 2'd0;
            r_bit       <= 3'd0;
            r_left      <= 8'd0;
            r_hold_full <= 1'b0;
            r_ack_cnt   <= 16'd0;
            r_is_read   <= 1'b0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_qtr       <= n_qtr;
            r_bit       <= n_bit;
            r_left      <= n_left;
            r_hold_full <= n_hold_full;
            r_ack_cnt   <= n_ack_cnt;
            r_is_read   <= n_is_read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_shift <= n_shift;
            r_hdr0  <= n_hdr0;
            r_hdr1  <= n_hdr1;
            r_hdr2  <= n_hdr2;
            r_hold  <= n_hold;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/i2cm_checker.sv =====
// Port-level checks for the I2C master transaction engine and their binding.
`default_nettype none

module i2cm_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [15:0] m_axis_tdata,
    input  wire logic        m_axis_tuser,
    input  wire logic        m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_last_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
        else $error("last read without read byte");

    a_status_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[13] |-> m_axis_tdata[12])
        else $error("abort status without end of transaction");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[12] |-> !m_axis_tdata[2] && m_axis_tdata[0]
            && m_axis_tdata[1])
        else $error("bus not released at end of transaction");

    a_idle_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[11:4] == 8'd0)
        else $error("read byte set without read valid");

endmodule

bind i2c_master_transaction_engine i2cm_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking bench for the I2C master transaction engine: stream stimulus and result checks.
`timescale 1ns / 100ps

module tb;
    import i2cm_pkg::*;

    localparam int LIMIT     = 600000;
    localparam int PER_PHASE = 60;
    localparam int CALM_LO   = 1200;
    localparam int CALM_HI   = 2000;

    typedef enum logic [4:0] {
        BUS_IDLE, BUS_START, BUS_HDR0, BUS_HDR0_ACK, BUS_HDR1, BUS_HDR1_ACK,
        BUS_DATA, BUS_DATA_ACK, BUS_RESTART, BUS_HDR2, BUS_HDR2_ACK, BUS_READ,
        BUS_MACK, BUS_STOP, BUS_ABORT, BUS_STALL
    } t_phase;

    typedef struct packed {
        t_phase      ph;
        logic [1:0]  q;
        logic [3:0]  bit_n;
        logic [7:0]  sh;
        logic [7:0]  h0;
        logic [7:0]  h1;
        logic [7:0]  h2;
        logic [7:0]  left;
        logic [7:0]  hold;
        logic        hold_full;
        logic [15:0] wait_n;
        logic        rd;
        logic [15:0] tmo;
    } t_bus;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = KIND_TICK;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    t_item   bus_items[$];
    t_result due_results[$];
    t_bus    gen_bus;
    t_bus    chk_bus;
    int      nack_at = -1;
    int      acks_seen = 0;
    int      data_rate = 50;
    int      cycles = 0;
    int      fails = 0;
    int      n_out = 0;
    int      n_in = 0;
    int      n_xfer = 0;
    int      n_abort = 0;
    int      n_rbytes = 0;
    int      stall_left = 0;
    logic    stall_done = 1'b0;
    logic    took = 1'b0;
    logic    calm;

    assign calm = (cycles >= CALM_LO) && (cycles < CALM_HI);

    i2c_master_transaction_engine dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic is_ack(input t_phase p);
        return (p == BUS_HDR0_ACK) || (p == BUS_HDR1_ACK) || (p == BUS_HDR2_ACK) ||
               (p == BUS_DATA_ACK);
    endfunction

    task automatic go(inout t_bus s, input t_phase p);
        s.ph = p;
        s.q = 2'd0;
        s.bit_n = 4'd0;
    endtask

    task automatic load(inout t_bus s, input t_phase p, input logic [7:0] v);
        go(s, p);
        s.sh = v;
    endtask

    task automatic next_data(inout t_bus s);
        if (s.hold_full) begin
            load(s, BUS_DATA, s.hold);
            s.hold_full = 1'b0;
            s.left = s.left - 8'd1;
        end else begin
            go(s, BUS_STALL);
        end
    endtask

    task automatic bus_step(inout t_bus s, input t_item it, output t_result r);
        logic       lastq;
        logic       hi;
        logic [1:0] q;
        r = '0;
        lastq = (s.q == 2'd3);
        case (it.kind)
            KIND_WRITE, KIND_READ: begin
                if (s.ph == BUS_IDLE) begin
                    s.h0 = it.first_byte;
                    s.h1 = it.second_byte;
                    s.h2 = it.third_byte;
                    s.left = it.byte_count;
                    s.rd = (it.kind == KIND_READ);
                    s.hold_full = 1'b0;
                    s.wait_n = 16'd0;
                    go(s, BUS_START);
                end
            end
            KIND_DATA: begin
                if (s.ph != BUS_IDLE && !s.rd && !s.hold_full) begin
                    s.hold = it.data_byte;
                    s.hold_full = 1'b1;
                end
            end
            default: begin
                if (s.ph != BUS_IDLE) begin
                    case (s.ph)
                        BUS_START: begin
                            if (!lastq) s.q = s.q + 2'd1;
                            else load(s, BUS_HDR0, s.h0);
                        end
                        BUS_HDR0, BUS_HDR1, BUS_HDR2, BUS_DATA: begin
                            if (!lastq) begin
                                s.q = s.q + 2'd1;
                            end else if (s.bit_n < 4'd7) begin
                                s.bit_n = s.bit_n + 4'd1;
                                s.sh = s.sh << 1;
                                s.q = 2'd0;
                            end else begin
                                case (s.ph)
                                    BUS_HDR0: go(s, BUS_HDR0_ACK);
                                    BUS_HDR1: go(s, BUS_HDR1_ACK);
                                    BUS_HDR2: go(s, BUS_HDR2_ACK);
                                    default:  go(s, BUS_DATA_ACK);
                                endcase
                                s.wait_n = 16'd0;
                            end
                        end
                        BUS_HDR0_ACK, BUS_HDR1_ACK, BUS_HDR2_ACK, BUS_DATA_ACK: begin
                            if (!lastq) begin
                                s.q = s.q + 2'd1;
                            end else if (!it.sda_in) begin
                                case (s.ph)
                                    BUS_HDR0_ACK: load(s, BUS_HDR1, s.h1);
                                    BUS_HDR1_ACK: begin
                                        if (s.rd) go(s, BUS_RESTART);
                                        else if (s.left == 8'd0) go(s, BUS_STOP);
                                        else next_data(s);
                                    end
                                    BUS_HDR2_ACK: begin
                                        if (s.left == 8'd0) begin
                                            go(s, BUS_STOP);
                                        end else begin
                                            go(s, BUS_READ);
                                            s.sh = 8'd0;
                                        end
                                    end
                                    default: begin
                                        if (s.left == 8'd0) go(s, BUS_STOP);
                                        else next_data(s);
                                    end
                                endcase
                            end else if (s.wait_n >= s.tmo) begin
                                go(s, BUS_ABORT);
                            end else begin
                                s.wait_n = s.wait_n + 16'd1;
                            end
                        end
                        BUS_STALL: next_data(s);
                        BUS_RESTART: begin
                            if (!lastq) s.q = s.q + 2'd1;
                            else load(s, BUS_HDR2, s.h2);
                        end
                        BUS_READ: begin
                            if (!lastq) begin
                                s.q = s.q + 2'd1;
                            end else begin
                                s.sh = {s.sh[6:0], it.sda_in};
                                if (s.bit_n < 4'd7) begin
                                    s.bit_n = s.bit_n + 4'd1;
                                    s.q = 2'd0;
                                end else begin
                                    if (s.left != 8'd0) s.left = s.left - 8'd1;
                                    r.read_byte = s.sh;
                                    r.read_valid = 1'b1;
                                    r.last_read = (s.left == 8'd0);
                                    go(s, BUS_MACK);
                                end
                            end
                        end
                        BUS_MACK: begin
                            if (!lastq) begin
                                s.q = s.q + 2'd1;
                            end else if (s.left == 8'd0) begin
                                go(s, BUS_STOP);
                            end else begin
                                go(s, BUS_READ);
                                s.sh = 8'd0;
                            end
                        end
                        BUS_STOP, BUS_ABORT: begin
                            if (!lastq) begin
                                s.q = s.q + 2'd1;
                            end else begin
                                r.done_res = 1'b1;
                                r.status = (s.ph == BUS_ABORT);
                                s.hold_full = 1'b0;
                                go(s, BUS_IDLE);
                            end
                        end
                        default: go(s, BUS_IDLE);
                    endcase
                end
            end
        endcase

        q = s.q;
        hi = (q >= 2'd2);
        case (s.ph)
            BUS_START: begin
                r.scl_out = (q < 2'd2);
                r.sda_out = (q == 2'd0);
            end
            BUS_HDR0, BUS_HDR1, BUS_HDR2, BUS_DATA: begin
                r.scl_out = hi;
                r.sda_out = s.sh[7];
            end
            BUS_HDR0_ACK, BUS_HDR1_ACK, BUS_HDR2_ACK, BUS_DATA_ACK, BUS_READ: begin
                r.scl_out = hi;
                r.sda_out = 1'b1;
            end
            BUS_RESTART: begin
                r.scl_out = (q == 2'd1) || (q == 2'd2);
                r.sda_out = (q < 2'd2);
            end
            BUS_MACK: begin
                r.scl_out = hi;
                r.sda_out = (s.left == 8'd0);
            end
            BUS_STOP, BUS_ABORT: begin
                r.scl_out = (q >= 2'd1);
                r.sda_out = hi;
            end
            BUS_STALL: begin
                r.scl_out = 1'b0;
                r.sda_out = 1'b1;
            end
            default: begin
                r.scl_out = 1'b1;
                r.sda_out = 1'b1;
            end
        endcase
        r.busy_res = (s.ph != BUS_IDLE);
        r.need_data = (s.ph != BUS_IDLE) && !s.rd && (s.left != 8'd0) && !s.hold_full;
    endtask

    // Queue one transaction and track the plan for the acknowledge the slave withholds.
    task automatic emit(input t_item it);
        t_phase  was;
        t_result unused;
        was = gen_bus.ph;
        bus_step(gen_bus, it, unused);
        if (was == BUS_IDLE && gen_bus.ph == BUS_START) begin
            acks_seen = 0;
            data_rate = $urandom_range(2, 70);
            if (gen_bus.tmo > 16'd2000) nack_at = -1;
            else if (gen_bus.left > 8'd8) nack_at = $urandom_range(0, 2);
            else if ($urandom_range(0, 4) == 0)
                nack_at = $urandom_range(0, gen_bus.rd ? 2 : int'(gen_bus.left) + 1);
            else nack_at = -1;
        end else if (gen_bus.ph != was && is_ack(gen_bus.ph)) begin
            acks_seen++;
        end
        bus_items.push_back(it);
    endtask

    task automatic make_item(input logic with_noise, output t_item it, output logic junk);
        int roll;
        it.kind = KIND_TICK;
        it.first_byte = 8'($urandom_range(0, 255));
        it.second_byte = 8'($urandom_range(0, 255));
        it.third_byte = 8'($urandom_range(0, 255));
        it.byte_count = 8'($urandom_range(0, 255));
        it.data_byte = 8'($urandom_range(0, 255));
        it.sda_in = 1'($urandom_range(0, 1));
        junk = 1'b0;
        roll = $urandom_range(0, 99);
        if (with_noise && roll < 6) begin
            junk = 1'b1;
            if (gen_bus.ph == BUS_IDLE) it.kind = roll[0] ? KIND_DATA : KIND_TICK;
            else it.kind = t_kind'($urandom_range(1, 3));
        end else if (gen_bus.ph == BUS_IDLE) begin
            it.kind = roll[0] ? KIND_READ : KIND_WRITE;
            if (gen_bus.tmo > 16'd2000) it.byte_count = 8'($urandom_range(0, 8));
            else if ($urandom_range(0, 9) != 0) it.byte_count = 8'($urandom_range(0, 5));
        end else if (!gen_bus.rd && gen_bus.left != 8'd0 && !gen_bus.hold_full &&
                     $urandom_range(0, 99) < data_rate) begin
            it.kind = KIND_DATA;
        end else if (is_ack(gen_bus.ph) && gen_bus.q == 2'd3) begin
            it.sda_in = (acks_seen - 1 == nack_at) ||
                        (gen_bus.wait_n < gen_bus.tmo && $urandom_range(0, 3) == 0);
        end
    endtask

    task automatic run_out();
        t_item it;
        logic  junk;
        while (gen_bus.ph != BUS_IDLE) begin
            make_item(1'b0, it, junk);
            emit(it);
        end
    endtask

    task automatic begin_txn(input t_kind k, input logic [7:0] b0, input logic [7:0] b1,
                             input logic [7:0] b2, input logic [7:0] cnt, input int nack);
        t_item it;
        it = '0;
        it.kind = k;
        it.first_byte = b0;
        it.second_byte = b1;
        it.third_byte = b2;
        it.byte_count = cnt;
        emit(it);
        nack_at = nack;
    endtask

    task automatic run_random(input int n);
        t_item it;
        logic  junk;
        int    done_n;
        done_n = 0;
        while (done_n < n || gen_bus.ph != BUS_IDLE) begin
            make_item(1'b1, it, junk);
            emit(it);
            if (!junk) done_n++;
        end
    endtask

    task automatic drain();
        while (bus_items.size() != 0 || due_results.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    task automatic apb_read_check(input logic [15:0] want);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {REG_ACK_TIMEOUT, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field("ack_timeout", int'(want), int'(prdata));
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Sender: hold an offered transaction until taken, otherwise offer the next or idle.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || took) begin
            if (bus_items.size() != 0 && (calm || $urandom_range(0, 99) >= 32)) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {7'd0, bus_items[0].sda_in, bus_items[0].data_byte,
                                 bus_items[0].byte_count, bus_items[0].third_byte,
                                 bus_items[0].second_byte, bus_items[0].first_byte};
                s_axis_tuser <= bus_items[0].kind;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= i_rst_n && (stall_left == 0) && (calm || $urandom_range(0, 99) >= 32);
    end

    // Hold the receiver off once for a long stretch so the engine backs up.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (!stall_done && n_out >= 150) begin
            stall_left <= 300;
            stall_done <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : mon_blk
        t_result pred;
        t_result want;
        cycles <= cycles + 1;
        took <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            bus_step(chk_bus, bus_items[0], pred);
            due_results.push_back(pred);
            void'(bus_items.pop_front());
            n_in++;
            if (pred.done_res) n_xfer++;
            if (pred.done_res && pred.status) n_abort++;
            if (pred.read_valid) n_rbytes++;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_out <= n_out + 1;
            if (due_results.size() == 0) begin
                $error("result arrived with nothing outstanding");
                fails++;
            end else begin
                want = due_results.pop_front();
                check_field("scl_out", int'(want.scl_out), int'(m_axis_tdata[0]));
                check_field("sda_out", int'(want.sda_out), int'(m_axis_tdata[1]));
                check_field("busy_res", int'(want.busy_res), int'(m_axis_tdata[2]));
                check_field("need_data", int'(want.need_data), int'(m_axis_tdata[3]));
                check_field("read_byte", int'(want.read_byte), int'(m_axis_tdata[11:4]));
                check_field("done_res", int'(want.done_res), int'(m_axis_tdata[12]));
                check_field("status", int'(want.status), int'(m_axis_tdata[13]));
                check_field("read_valid", int'(want.read_valid), int'(m_axis_tuser));
                check_field("last_read", int'(want.last_read), int'(m_axis_tlast));
            end
        end
        if (cycles >= LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycles, due_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        t_item       it;
        int          k;
        logic [15:0] tmo_set[5];
        logic [15:0] tmo;
        tmo_set = '{16'd0, 16'd65535, 16'd1, 16'd3, 16'd0};
        tmo_set[4] = 16'($urandom_range(4, 40));
        gen_bus = '0;
        gen_bus.tmo = 16'(ACK_TIMEOUT_RESET);
        chk_bus = gen_bus;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        apb_read_check(16'(ACK_TIMEOUT_RESET));

        it = '0;
        emit(it);
        it = '1;
        it.kind = KIND_DATA;
        emit(it);
        begin_txn(KIND_WRITE, 8'hFF, 8'h00, 8'h00, 8'h00, -1);
        run_out();
        begin_txn(KIND_WRITE, 8'h00, 8'hFF, 8'h00, 8'h02, -1);
        it = '1;
        it.kind = KIND_READ;
        emit(it);
        it = '0;
        it.kind = KIND_DATA;
        emit(it);
        it.data_byte = 8'hFF;
        emit(it);
        run_out();
        begin_txn(KIND_READ, 8'hA5, 8'h5A, 8'hFF, 8'h01, -1);
        run_out();
        begin_txn(KIND_READ, 8'hFF, 8'hFF, 8'h00, 8'hFF, 0);
        run_out();
        begin_txn(KIND_WRITE, 8'h3C, 8'hC3, 8'h00, 8'h03, 3);
        run_out();
        run_random(PER_PHASE);

        for (k = 0; k < 5; k++) begin
            tmo = tmo_set[k];
            drain();
            @(negedge i_clk);
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= {REG_ACK_TIMEOUT, 2'b00};
            pwdata <= {16'd0, tmo};
            @(negedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            gen_bus.tmo = tmo;
            chk_bus.tmo = tmo;
            @(negedge i_clk);
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
            apb_read_check(tmo);
            run_random(PER_PHASE);
        end
        drain();

        $display("Ran %0d bus steps over six ack_timeout settings, %0d transfers closed",
                 n_in, n_xfer);
        $display("(%0d ended on acknowledge timeout), %0d read bytes returned",
                 n_abort, n_rbytes);
        if (fails == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== i2c_master_transaction_engine.f =====
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_regs.sv
rtl/core/i2cm_core.sv
rtl/core/i2c_master_transaction_engine.sv
rtl/core/i2cm_checker.sv
sim/tb.sv
